// ----- rtl/core/hmlos_pkg.sv -----
// Height map line-of-sight: shared constants, codes and controller/datapath types.
// No dependencies; imported by hmlos_ctrl, hmlos_datapath, the top level and the testbench.
`default_nettype none

package hmlos_pkg;

  // Default sizes for the top-level parameters
  localparam int BOARD_MAX_DEF   = 32;
  localparam int MARCH_STEPS_DEF = 100;
  localparam int HEIGHT_BITS_DEF = 6;

  // Fixed field widths
  localparam int COORD_W    = 5;   // square coordinates
  localparam int CELL_H_W   = 6;   // cell_height field
  localparam int Q_W        = 16;  // signed Q7.8 fields
  localparam int CFG_W      = 6;   // board size registers
  localparam int DIST_BITS  = 16;  // magnitude of a per-axis distance
  localparam int POS_W      = 18;  // signed march position (Q7.8 with headroom)
  localparam int SQ_W       = 11;  // rounded square magnitude
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 8;

  localparam logic [CFG_W-1:0] BOARD_SIZE_RST = 6'd32;

  // Result outcome codes
  typedef enum logic [2:0] {
    OUT_WRITE   = 3'd0,
    OUT_ABOVE   = 3'd1,
    OUT_REACHED = 3'd2,
    OUT_BLOCKED = 3'd3,
    OUT_DONE    = 3'd4
  } outcome_t;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_reg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic     load;        // capture input item
    logic     wr_cell;     // write height map cell
    logic     div_start;   // load step magnitudes and march start point
    logic     div_quo;     // step quotient by reciprocal multiply
    logic     div_rmd;     // step remainder from quotient
    logic     adv;         // advance march one step
    logic     adv_last;    // this advance is the final step
    logic     res_we;      // load result register
    logic     res_march;   // result comes from march
    outcome_t res_code;    // result code when not from march
    logic     post;        // move result to output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_query;
    logic above;
    logic march_done;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/hmlos_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module hmlos_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire                       clk,
  input  wire                       we,
  input  wire [$clog2(DEPTH)-1:0]   waddr,
  input  wire [WIDTH-1:0]           wdata,
  input  wire [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/hmlos_ctrl.sv -----
// Height map line-of-sight controller: sequences capture, divide, march and result post.
// Depends on hmlos_pkg.
`default_nettype none

module hmlos_ctrl
  import hmlos_pkg::*;
#(
  parameter int MARCH_STEPS = MARCH_STEPS_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  stat_t       stat,
  output cmd_t        cmd
);

  localparam int JW  = $clog2(MARCH_STEPS + 1);
  localparam logic [JW-1:0]  J_END  = JW'(MARCH_STEPS);
  localparam logic [JW-1:0]  J_LAST = JW'(MARCH_STEPS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_QUOT,
    ST_REM,
    ST_MARCH,
    ST_POST
  } state_t;

  state_t         state, state_next;
  logic [JW-1:0]  jcnt, jcnt_next;

  // next state and commands
  always_comb begin
    state_next   = state;
    jcnt_next    = jcnt;
    cmd          = '0;
    cmd.res_code = OUT_WRITE;
    s_tready     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
        if (s_tvalid) begin
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (!stat.is_query) begin
          cmd.wr_cell  = 1'b1;
          cmd.res_we   = 1'b1;
          cmd.res_code = OUT_WRITE;
          state_next   = ST_POST;
        end else if (stat.above) begin
          cmd.res_we   = 1'b1;
          cmd.res_code = OUT_ABOVE;
          state_next   = ST_POST;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = ST_QUOT;
        end
      end
      ST_QUOT: begin
        cmd.div_quo = 1'b1;
        state_next  = ST_REM;
      end
      ST_REM: begin
        cmd.div_rmd = 1'b1;
        jcnt_next   = JW'(1);
        state_next  = ST_MARCH;
      end
      ST_MARCH: begin
        if (jcnt < J_END) begin
          cmd.adv      = 1'b1;
          cmd.adv_last = (jcnt == J_LAST);
          jcnt_next    = jcnt + 1'b1;
        end
        if (stat.march_done) begin
          cmd.res_we    = 1'b1;
          cmd.res_march = 1'b1;
          state_next    = ST_POST;
        end
      end
      ST_POST: begin
        if (stat.out_free) begin
          cmd.post   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      jcnt    <= '0;
    end else begin
      state   <= state_next;
      jcnt    <= jcnt_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/hmlos_datapath.sv -----
// Height map line-of-sight datapath: item capture, board registers, height map,
// per-axis step size by reciprocal multiply, three-stage march pipeline and results.
// Depends on hmlos_pkg and hmlos_ram.
`default_nettype none

module hmlos_datapath
  import hmlos_pkg::*;
#(
  parameter int BOARD_MAX   = BOARD_MAX_DEF,
  parameter int MARCH_STEPS = MARCH_STEPS_DEF,
  parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   cfg_we,
  input  wire [0:0]             cfg_index,
  input  wire [CFG_W-1:0]       cfg_data,
  input  wire [IN_DATA_W-1:0]   s_tdata,
  input  wire                   s_tuser,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  output logic                  m_tvalid,
  input  wire                   m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata
);

  localparam int AW   = $clog2(BOARD_MAX * BOARD_MAX);
  localparam int RW   = $clog2(MARCH_STEPS);
  localparam int CMPW = (HEIGHT_BITS + 8 > POS_W) ? HEIGHT_BITS + 8 : POS_W;
  localparam logic [RW:0]     STEPS_W  = (RW + 1)'(MARCH_STEPS);
  localparam logic [RW-1:0]   HALF_W   = RW'(MARCH_STEPS / 2);
  localparam logic [SQ_W-1:0] BMAX_SQ  = SQ_W'(BOARD_MAX);
  localparam logic [AW-1:0]   BMAX_A   = AW'(BOARD_MAX);

  // reciprocal of MARCH_STEPS, exact floor for every DIST_BITS-bit magnitude
  localparam int     RSH   = DIST_BITS + RW;
  localparam int     PW    = 2 * DIST_BITS + 1;
  localparam longint RECIP = ((longint'(1) << RSH) + longint'(MARCH_STEPS) - 1)
                             / longint'(MARCH_STEPS);
  localparam logic [DIST_BITS:0]   RECIP_K = (DIST_BITS + 1)'(RECIP);
  localparam logic [DIST_BITS-1:0] STEPS_Q = DIST_BITS'(MARCH_STEPS);

  // captured item
  logic                    act, sfb;
  logic [COORD_W-1:0]      cx, cy, tx, ty;
  logic [CELL_H_W-1:0]     ch;
  logic signed [Q_W-1:0]   ex, ey, ez, tz;

  // board size registers
  logic [CFG_W-1:0]        board_width, board_height;

  // step size and march state, index 0 = x, 1 = y, 2 = z
  logic [DIST_BITS-1:0]    div_num  [3];
  logic [DIST_BITS-1:0]    div_quo  [3];
  logic [RW-1:0]           div_rem  [3];
  logic [PW-1:0]           quo_prod [3];
  logic [DIST_BITS-1:0]    quo_back [3];
  logic                    neg      [3];
  logic signed [POS_W-1:0] pos      [3];
  logic [RW-1:0]           frac     [3];

  logic signed [POS_W-1:0] delta     [3];
  logic signed [POS_W-1:0] start_p   [3];
  logic [DIST_BITS-1:0]    delta_mag [3];

  // pipeline stage registers
  logic                    a_vld, a_last, b_vld, b_last, b_off;
  logic signed [POS_W-1:0] b_pz;

  // result and output registers
  logic                    res_vis, out_vis;
  outcome_t                res_code, out_code;

  // RAM signals
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr, ram_raddr;
  logic [HEIGHT_BITS-1:0]  ram_rdata;

  // input item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act <= s_tuser;
      cx  <= s_tdata[4:0];
      cy  <= s_tdata[9:5];
      ch  <= s_tdata[15:10];
      ex  <= s_tdata[31:16];
      ey  <= s_tdata[47:32];
      ez  <= s_tdata[63:48];
      tx  <= s_tdata[68:64];
      ty  <= s_tdata[73:69];
      tz  <= s_tdata[89:74];
      sfb <= s_tdata[90];
    end
  end

  // board size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      board_width  <= BOARD_SIZE_RST;
      board_height <= BOARD_SIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDTH:  board_width  <= cfg_data;
        CFG_HEIGHT: board_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective board limits
  logic [SQ_W-1:0] w_lim, h_lim;
  always_comb begin
    w_lim = (SQ_W'(board_width) > BMAX_SQ) ? BMAX_SQ : SQ_W'(board_width);
    h_lim = (SQ_W'(board_height) > BMAX_SQ) ? BMAX_SQ : SQ_W'(board_height);
  end

  // per-axis distance from eye to target and its magnitude
  always_comb begin
    start_p[0] = POS_W'(ex);
    start_p[1] = POS_W'(ey);
    start_p[2] = POS_W'(ez);
    delta[0] = $signed({5'b0, tx, 8'b0}) - start_p[0];
    delta[1] = $signed({5'b0, ty, 8'b0}) - start_p[1];
    delta[2] = POS_W'(tz) - start_p[2];
    for (int i = 0; i < 3; i++) begin
      delta_mag[i] = delta[i][POS_W-1] ? DIST_BITS'(-delta[i]) : DIST_BITS'(delta[i]);
    end
  end

  // |delta| = q * MARCH_STEPS + r: q by reciprocal multiply, r in the next cycle
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      quo_prod[i] = PW'(div_num[i]) * PW'(RECIP_K);
      quo_back[i] = div_quo[i] * STEPS_Q;
    end
  end

  // divider and march registers: pos steps by q per step, frac carries the remainder with rounding bias
  always_ff @(posedge clk) begin
    logic [RW:0]        fsum;
    logic               carry;
    logic [DIST_BITS:0] inc;
    for (int i = 0; i < 3; i++) begin
      if (cmd.div_start) begin
        div_num[i] <= delta_mag[i];
        neg[i]     <= delta[i][POS_W-1];
        pos[i]     <= start_p[i];
        frac[i]    <= HALF_W;
      end else if (cmd.div_quo) begin
        div_quo[i] <= DIST_BITS'(quo_prod[i] >> RSH);
      end else if (cmd.div_rmd) begin
        div_rem[i] <= RW'(div_num[i] - quo_back[i]);
      end else if (cmd.adv) begin
        fsum  = {1'b0, frac[i]} + {1'b0, div_rem[i]};
        carry = (fsum >= STEPS_W);
        frac[i] <= carry ? RW'(fsum - STEPS_W) : RW'(fsum);
        inc = {1'b0, div_quo[i]} + (DIST_BITS + 1)'(carry);
        pos[i] <= neg[i] ? pos[i] - POS_W'(inc) : pos[i] + POS_W'(inc);
      end
    end
  end

  // stage B: round position to a square, check board edges and target
  logic [POS_W-1:0] mag_x, mag_y;
  logic [POS_W:0]   rnd_x, rnd_y;
  logic [SQ_W-1:0]  sq_x, sq_y;
  logic             sneg_x, sneg_y, off_now;
  always_comb begin
    mag_x  = pos[0][POS_W-1] ? POS_W'(-pos[0]) : POS_W'(pos[0]);
    mag_y  = pos[1][POS_W-1] ? POS_W'(-pos[1]) : POS_W'(pos[1]);
    rnd_x  = {1'b0, mag_x} + (POS_W + 1)'(128);
    rnd_y  = {1'b0, mag_y} + (POS_W + 1)'(128);
    sq_x   = rnd_x[8 +: SQ_W];
    sq_y   = rnd_y[8 +: SQ_W];
    sneg_x = pos[0][POS_W-1] && (sq_x != '0);
    sneg_y = pos[1][POS_W-1] && (sq_y != '0);
    off_now = sneg_x || sneg_y || (sq_x >= w_lim) || (sq_y >= h_lim)
              || (!sneg_x && !sneg_y && sq_x == SQ_W'(tx) && sq_y == SQ_W'(ty));
    ram_raddr = AW'(AW'(sq_y) * BMAX_A + AW'(sq_x));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld  <= 1'b0;
      a_last <= 1'b0;
      b_vld  <= 1'b0;
      b_last <= 1'b0;
    end else begin
      a_vld  <= cmd.adv;
      a_last <= cmd.adv_last;
      b_vld  <= a_vld;
      b_last <= a_last;
    end
  end

  always_ff @(posedge clk) begin
    b_off <= off_now;
    b_pz  <= pos[2];
  end

  // stage C: terrain compare against height map data
  logic [CMPW-1:0] cell_q, pz_u;
  logic            cell_ge;
  always_comb begin
    cell_q  = CMPW'({ram_rdata, 8'b0});
    pz_u    = CMPW'(unsigned'(b_pz));
    cell_ge = b_pz[POS_W-1] || (cell_q >= pz_u);
  end

  // height map
  always_comb begin
    ram_we    = cmd.wr_cell && (SQ_W'(cx) < BMAX_SQ) && (SQ_W'(cy) < BMAX_SQ);
    ram_waddr = AW'(AW'(cy) * BMAX_A + AW'(cx));
  end

  hmlos_ram #(
    .WIDTH (HEIGHT_BITS),
    .DEPTH (BOARD_MAX * BOARD_MAX)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (HEIGHT_BITS'(ch)),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (cmd.res_we) begin
      if (cmd.res_march) begin
        if (b_off) begin
          res_vis  <= 1'b1;
          res_code <= OUT_REACHED;
        end else if (cell_ge) begin
          res_vis  <= 1'b0;
          res_code <= OUT_BLOCKED;
        end else begin
          res_vis  <= 1'b1;
          res_code <= OUT_DONE;
        end
      end else begin
        res_vis  <= 1'b0;
        res_code <= cmd.res_code;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.post) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.post) begin
      out_vis  <= res_vis;
      out_code <= res_code;
    end
  end

  assign m_tdata = {4'b0, out_code, out_vis};

  // status
  always_comb begin
    stat.is_query   = act;
    stat.above      = !sfb && (tz >= ez);
    stat.march_done = b_vld && (b_off || cell_ge || b_last);
    stat.out_free   = !m_tvalid || m_tready;
  end

endmodule

`default_nettype wire

// ----- rtl/core/heightmap_line_of_sight.sv -----
// Height map line-of-sight: top level joining controller and datapath.
// Depends on hmlos_pkg, hmlos_ctrl, hmlos_datapath (and hmlos_ram below it).
//
// Usage:
//   Input items arrive on s_*: s_tuser = 0 writes one height map cell, 1 asks
//   a visibility query. Every item gives exactly one result item on m_*.
//   Board size registers are written on cfg_we / cfg_index / cfg_data; the user must
//   write them only while no item is in flight (not enforced); both reset to 32.
// Sequencing:
//   For a cell write, or a query that fails the above-eye test, the controller
//   goes from dispatch straight to post; m_tvalid rises once the result is
//   posted and the next item is taken after that. A marching query first
//   computes the step size (reciprocal multiply, then remainder), then runs
//   one march step per cycle through a three-stage pipeline (position,
//   square / map read, terrain compare) until a step decides or the last
//   step is done; the result is then posted and the next item follows.
//   One item at a time; the single height map read port sets the march rate.
// Reset and stall:
//   rst (synchronous) returns the controller to idle, empties the output
//   register and sets the board size to 32; height map contents are kept
//   and count as undefined until written. A result waits in the output
//   register while m_tready is low; the next item is still accepted and
//   worked on, and its result holds until the output register frees.
`default_nettype none

module heightmap_line_of_sight
  import hmlos_pkg::*;
#(
  parameter int BOARD_MAX   = BOARD_MAX_DEF,
  parameter int MARCH_STEPS = MARCH_STEPS_DEF,
  parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
) (
  input  wire                   clk,
  input  wire                   rst,
  // configuration write port
  input  wire                   cfg_we,
  input  wire [0:0]             cfg_index,
  input  wire [CFG_W-1:0]       cfg_data,
  // input items
  input  wire                   s_tvalid,
  output logic                  s_tready,
  // s_tdata from bit 0: cell_x[5], cell_y[5], cell_height[6], eye_x[16], eye_y[16],
  // eye_z[16], target_x[5], target_y[5], target_alt[16], see_from_below[1], zero pad
  input  wire [IN_DATA_W-1:0]   s_tdata,
  // s_tuser: action
  input  wire                   s_tuser,
  // result items
  output logic                  m_tvalid,
  input  wire                   m_tready,
  // m_tdata from bit 0: visible[1], outcome[3], zero pad
  output logic [OUT_DATA_W-1:0] m_tdata
);

  cmd_t  cmd;
  stat_t stat;

  hmlos_ctrl #(
    .MARCH_STEPS (MARCH_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  hmlos_datapath #(
    .BOARD_MAX   (BOARD_MAX),
    .MARCH_STEPS (MARCH_STEPS),
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd       (cmd),
    .stat      (stat),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Testbench for heightmap_line_of_sight: fills the height map, then runs directed
// and random cell writes and sight queries against a built-in predictor.
// Depends on hmlos_pkg and the heightmap_line_of_sight RTL.
`default_nettype none

module tb;
  import hmlos_pkg::*;

  localparam int BOARD   = BOARD_MAX_DEF;
  localparam int STEPS   = MARCH_STEPS_DEF;
  localparam int PERIOD  = 12;
  localparam int DRAIN_CYCLES = MARCH_STEPS_DEF + 30;

  // One input item, unpacked
  typedef struct {
    logic               action;
    logic [4:0]         cell_x;
    logic [4:0]         cell_y;
    logic [5:0]         cell_height;
    logic signed [15:0] eye_x;
    logic signed [15:0] eye_y;
    logic signed [15:0] eye_z;
    logic [4:0]         target_x;
    logic [4:0]         target_y;
    logic signed [15:0] target_alt;
    logic               see_from_below;
  } sight_item_t;

  typedef struct {
    logic     visible;
    outcome_t outcome;
  } sight_result_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [0:0]            cfg_index = CFG_WIDTH;
  logic [CFG_W-1:0]      cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  // Predictor state: shadow height map and board size registers
  logic [5:0]       terrain [0:BOARD*BOARD-1];
  logic [CFG_W-1:0] board_w = BOARD_SIZE_RST;
  logic [CFG_W-1:0] board_h = BOARD_SIZE_RST;

  sight_result_t pending_results[$];
  int            error_count = 0;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;

  heightmap_line_of_sight u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #(PERIOD/2) clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #(2_000_000 * PERIOD);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // round(num / STEPS), half away from zero
  function automatic longint step_frac(input longint num);
    longint mag;
    mag = (num < 0) ? -num : num;
    mag = (mag + STEPS / 2) / STEPS;
    return (num < 0) ? -mag : mag;
  endfunction

  // Q7.8 to whole square, half away from zero
  function automatic longint square_of(input longint v);
    longint mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + 128) / 256;
    return (v < 0) ? -mag : mag;
  endfunction

  // Expected result of one item; a cell write also updates the shadow map
  function automatic sight_result_t predict_sight(input sight_item_t it);
    sight_result_t r;
    longint ex, ey, ez, tx, ty, dx, dy, dz, pz, sx, sy, w, h;
    r.visible = 1'b0;
    r.outcome = OUT_WRITE;
    if (!it.action) begin
      terrain[it.cell_y * BOARD + it.cell_x] = it.cell_height;
      return r;
    end
    ex = it.eye_x;
    ey = it.eye_y;
    ez = it.eye_z;
    tx = it.target_x;
    ty = it.target_y;
    if (!it.see_from_below && longint'(it.target_alt) >= ez) begin
      r.outcome = OUT_ABOVE;
      return r;
    end
    w  = (board_w > BOARD) ? BOARD : board_w;
    h  = (board_h > BOARD) ? BOARD : board_h;
    dx = tx * 256 - ex;
    dy = ty * 256 - ey;
    dz = longint'(it.target_alt) - ez;
    for (longint j = 1; j < STEPS; j++) begin
      sx = square_of(ex + step_frac(dx * j));
      sy = square_of(ey + step_frac(dy * j));
      pz = ez + step_frac(dz * j);
      if ((sx == tx && sy == ty) || sx < 0 || sx >= w || sy < 0 || sy >= h) begin
        r.visible = 1'b1;
        r.outcome = OUT_REACHED;
        return r;
      end
      if (longint'(terrain[sy * BOARD + sx]) * 256 >= pz) begin
        r.outcome = OUT_BLOCKED;
        return r;
      end
    end
    r.visible = 1'b1;
    r.outcome = OUT_DONE;
    return r;
  endfunction

  // Send one item; called and returns at a falling edge
  task automatic send_item(input sight_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.action;
    s_tdata  <= {5'b0, it.see_from_below, it.target_alt, it.target_y, it.target_x,
                 it.eye_z, it.eye_y, it.eye_x, it.cell_height, it.cell_y, it.cell_x};
    do @(posedge clk); while (!s_tready);
    pending_results = {pending_results, predict_sight(it)};
    @(negedge clk);
  endtask

  task automatic write_cell(input int x, input int y, input int hgt);
    sight_item_t it;
    it = '{default: '0};
    it.cell_x      = 5'(x);
    it.cell_y      = 5'(y);
    it.cell_height = 6'(hgt);
    it.eye_x       = 16'($urandom);
    it.target_alt  = 16'($urandom);
    send_item(it);
  endtask

  task automatic query(input int ex, input int ey, input int ez, input int tx, input int ty,
                       input int alt, input logic below_ok);
    sight_item_t it;
    it = '{default: '0};
    it.action         = 1'b1;
    it.cell_x         = 5'($urandom);
    it.cell_height    = 6'($urandom);
    it.eye_x          = 16'(ex);
    it.eye_y          = 16'(ey);
    it.eye_z          = 16'(ez);
    it.target_x       = 5'(tx);
    it.target_y       = 5'(ty);
    it.target_alt     = 16'(alt);
    it.see_from_below = below_ok;
    send_item(it);
  endtask

  // Query with mostly on-board eye points; one in ten is raw noise
  task automatic random_query();
    if ($urandom_range(9) == 0)
      query($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 1'($urandom));
    else
      query(int'($urandom_range(0, 32*256 - 1)) - 128, int'($urandom_range(0, 32*256 - 1)) - 128,
            $urandom_range(0, 80*256), $urandom_range(0, 31), $urandom_range(0, 31),
            $urandom_range(0, 40*256), $urandom_range(4) != 0);
  endtask

  // Mostly low terrain so that both visible and hidden answers come up
  function automatic int random_height();
    return ($urandom_range(3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 12);
  endfunction

  // Stop sending until every expected result is back
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic set_board(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    wait_for_results();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_WIDTH;
    cfg_data  <= w;
    @(negedge clk);
    cfg_index <= CFG_HEIGHT;
    cfg_data  <= h;
    @(negedge clk);
    cfg_we    <= 1'b0;
    board_w = w;
    board_h = h;
    @(negedge clk);
  endtask

  // Every cell gets written before any query may read it
  task automatic test_fill_map();
    for (int y = 0; y < BOARD; y++)
      for (int x = 0; x < BOARD; x++)
        write_cell(x, y, (x == y) ? 63 : random_height());
  endtask

  task automatic test_directed_cases();
    write_cell(0, 0, 0);
    write_cell(31, 31, 63);
    write_cell(5, 5, 63);
    // wall between eye and target
    query(2*256, 5*256, 10*256, 9, 5, 5*256, 1'b0);
    // high eye looking down across the board
    query(2*256, 2*256, 127*256, 20, 20, 0, 1'b0);
    // target at and above eye height with viewing from below off
    query(3*256, 3*256, 20*256, 10, 10, 20*256, 1'b0);
    query(3*256, 3*256, 20*256, 10, 10, 32767, 1'b0);
    // same target with viewing from below on, then extreme eye and target heights
    query(3*256, 3*256, 20*256, 10, 10, 20*256, 1'b1);
    query(0, 0, -32768, 31, 31, 32767, 1'b1);
    query(31*256, 31*256, 32767, 0, 0, -32768, 1'b0);
    // eye far off the board
    query(-32768, -32768, 32767, 0, 0, 0, 1'b0);
    query(32767, 32767, 32767, 31, 31, 0, 1'b0);
    // eye on the target square
    query(7*256, 7*256, 30*256, 7, 7, 0, 1'b0);
    // rounding of the eye square at the board edge and at half a square
    query(-128, 4*256, 70*256, 8, 4, 0, 1'b0);
    query(-127, 4*256, 70*256, 8, 4, 0, 1'b0);
    query(128, 128, 70*256, 12, 1, 0, 1'b0);
    query(31*256 + 127, 0, 70*256, 0, 31, 0, 1'b1);
  endtask

  // Extreme, zero and oversized board sizes
  task automatic test_board_sizes();
    logic [CFG_W-1:0] sizes [10][2] = '{'{1, 1}, '{32, 1}, '{1, 32}, '{0, 0}, '{0, 32},
                                       '{32, 0}, '{63, 63}, '{33, 5}, '{17, 32}, '{32, 32}};
    foreach (sizes[i]) begin
      set_board(sizes[i][0], sizes[i][1]);
      for (int n = 0; n < 12; n++) begin
        if ($urandom_range(9) == 0)
          write_cell($urandom, $urandom, random_height());
        else
          random_query();
      end
    end
  endtask

  task automatic test_random_traffic(input int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(49) == 0)
        wait_for_results();
      if ($urandom_range(4) == 0)
        write_cell($urandom, $urandom, random_height());
      else
        random_query();
    end
  endtask

  // Receiver backpressure
  always @(negedge clk)
    m_tready <= ($urandom_range(99) >= recv_idle_pct);

  // Result checker
  always @(posedge clk) begin : check_results
    sight_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        if (error_count < 10)
          $display("ERROR: result visible=%0d outcome=%0d with none expected",
                   m_tdata[0], m_tdata[3:1]);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[0] !== want.visible || m_tdata[3:1] !== want.outcome) begin
          if (error_count < 10)
            $display("ERROR: expected visible=%0d outcome=%s, got visible=%0d outcome=%0d",
                     want.visible, want.outcome.name(), m_tdata[0], m_tdata[3:1]);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle_pct = 9;
    recv_idle_pct = 64;
    test_fill_map();
    test_directed_cases();
    test_random_traffic(100);

    send_idle_pct = 64;
    recv_idle_pct = 9;
    test_board_sizes();
    set_board(CFG_W'($urandom_range(1, 32)), CFG_W'($urandom_range(1, 32)));
    test_random_traffic(100);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_board(CFG_W'($urandom_range(16, 32)), CFG_W'($urandom_range(16, 32)));
    test_random_traffic(130);

    // drain, then watch for stray results
    wait_for_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (pending_results.size() != 0) begin
      if (error_count < 10)
        $display("ERROR: expected %0d more results, got none", pending_results.size());
      error_count++;
    end

    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
